>>> rtl/gssim_pkg.sv
package gssim_pkg;

    // width of the shared serial datapath
    localparam int UNIT_W = 66;
    localparam int CNT_W = 7;
    localparam int SQRT_STEPS = 32;

    typedef logic [UNIT_W-1:0] word_t;
    typedef logic [UNIT_W:0] rem_t;
    typedef logic [CNT_W-1:0] cnt_t;

    localparam cnt_t DIV_LAST = cnt_t'(UNIT_W - 1);
    localparam cnt_t SQRT_LAST = cnt_t'(SQRT_STEPS - 1);
    localparam rem_t SQRT_BIT0 = rem_t'(1) << 62;

    // rounding offsets and fixed-point one
    localparam word_t RND_Q16 = word_t'(1) << 15;
    localparam word_t RND_Q24 = word_t'(1) << 23;
    localparam word_t RND_Q32 = word_t'(1) << 31;
    localparam word_t ONE_Q16 = word_t'(1) << 16;

    localparam logic [17:0] SSIM_POS_MAX = 18'd131071;
    localparam logic [17:0] SSIM_NEG_MAX = 18'd131072;
    localparam logic [32:0] VAR_CAP = 33'h07FFFFFFF;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_MUL,
        OP_DIV,
        OP_SQRT
    } op_t;

    typedef struct packed {
        logic  start;
        op_t   op;
        word_t a;
        word_t b;
    } unit_req_t;

    typedef struct packed {
        logic  busy;
        logic  done;
        word_t result;
    } unit_rsp_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_CHK,
        S_MX,
        S_MY,
        S_MXX,
        S_MYY,
        S_MXY,
        S_QX,
        S_QY,
        S_QXY,
        S_VAR,
        S_VV,
        S_SD,
        S_CDIV,
        S_TMAG,
        S_B,
        S_C,
        S_S,
        S_P,
        S_R,
        S_DONE
    } state_t;

endpackage

>>> rtl/gssim_accum.sv
module gssim_accum #(
    parameter int MAX_SAMPLES_LOG2 = 24
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          take,
    input  logic                          clear,
    input  logic [7:0]                    ref_pixel,
    input  logic [7:0]                    test_pixel,
    output logic [MAX_SAMPLES_LOG2:0]     count,
    output logic [MAX_SAMPLES_LOG2+7:0]   sum_ref,
    output logic [MAX_SAMPLES_LOG2+7:0]   sum_test,
    output logic [MAX_SAMPLES_LOG2+15:0]  sum_sq_ref,
    output logic [MAX_SAMPLES_LOG2+15:0]  sum_sq_test,
    output logic [MAX_SAMPLES_LOG2+15:0]  sum_cross
);

    localparam int L = MAX_SAMPLES_LOG2;

    logic [L:0]    count_reg;
    logic [L+7:0]  sum_ref_reg, sum_test_reg;
    logic [L+15:0] sum_sq_ref_reg, sum_sq_test_reg, sum_cross_reg;
    logic          room;

    // count saturates at 2^L, further pairs are dropped
    assign room = ~count_reg[L];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg       <= '0;
            sum_ref_reg     <= '0;
            sum_test_reg    <= '0;
            sum_sq_ref_reg  <= '0;
            sum_sq_test_reg <= '0;
            sum_cross_reg   <= '0;
        end
        else if (clear)
        begin
            count_reg       <= '0;
            sum_ref_reg     <= '0;
            sum_test_reg    <= '0;
            sum_sq_ref_reg  <= '0;
            sum_sq_test_reg <= '0;
            sum_cross_reg   <= '0;
        end
        else if (take && room)
        begin
            count_reg       <= count_reg + (L+1)'(1);
            sum_ref_reg     <= sum_ref_reg + (L+8)'(ref_pixel);
            sum_test_reg    <= sum_test_reg + (L+8)'(test_pixel);
            sum_sq_ref_reg  <= sum_sq_ref_reg
                               + (L+16)'({8'd0, ref_pixel} * {8'd0, ref_pixel});
            sum_sq_test_reg <= sum_sq_test_reg
                               + (L+16)'({8'd0, test_pixel} * {8'd0, test_pixel});
            sum_cross_reg   <= sum_cross_reg
                               + (L+16)'({8'd0, ref_pixel} * {8'd0, test_pixel});
        end
    end

    assign count       = count_reg;
    assign sum_ref     = sum_ref_reg;
    assign sum_test    = sum_test_reg;
    assign sum_sq_ref  = sum_sq_ref_reg;
    assign sum_sq_test = sum_sq_test_reg;
    assign sum_cross   = sum_cross_reg;

endmodule

>>> rtl/gssim_serial_unit.sv
module gssim_serial_unit (
    input  logic                  clk,
    input  logic                  rst_n,
    input  gssim_pkg::unit_req_t  req,
    output gssim_pkg::unit_rsp_t  rsp
);

    gssim_pkg::op_t   op_reg, op_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    gssim_pkg::word_t x_reg, x_next;
    gssim_pkg::word_t y_reg, y_next;
    gssim_pkg::rem_t  z_reg, z_next;
    gssim_pkg::cnt_t  cnt_reg, cnt_next;

    gssim_pkg::rem_t  trial;
    gssim_pkg::word_t root_sum;
    logic             ge;

    always_comb
    begin
        op_next   = op_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        cnt_next  = cnt_reg;
        trial     = {z_reg[gssim_pkg::UNIT_W-1:0], x_reg[gssim_pkg::UNIT_W-1]};
        root_sum  = y_reg + z_reg[gssim_pkg::UNIT_W-1:0];
        ge        = 1'b0;
        if (!busy_reg)
        begin
            if (req.start)
            begin
                op_next   = req.op;
                busy_next = (req.op != gssim_pkg::OP_NONE);
                cnt_next  = '0;
                x_next    = req.a;
                y_next    = (req.op == gssim_pkg::OP_SQRT) ? '0 : req.b;
                z_next    = (req.op == gssim_pkg::OP_SQRT) ? gssim_pkg::SQRT_BIT0 : '0;
            end
        end
        else
        begin
            unique case (op_reg)
                gssim_pkg::OP_MUL:
                begin
                    // shift-add, ends when multiplier runs out of ones
                    if (y_reg == '0)
                    begin
                        busy_next = 1'b0;
                        done_next = 1'b1;
                    end
                    else
                    begin
                        if (y_reg[0])
                            z_next = z_reg + {1'b0, x_reg};
                        x_next = x_reg << 1;
                        y_next = y_reg >> 1;
                    end
                end
                gssim_pkg::OP_DIV:
                begin
                    // restoring divide, one quotient bit a cycle
                    ge     = (trial >= {1'b0, y_reg});
                    z_next = ge ? (trial - {1'b0, y_reg}) : trial;
                    x_next = {x_reg[gssim_pkg::UNIT_W-2:0], ge};
                    cnt_next = cnt_reg + 1'b1;
                    if (cnt_reg == gssim_pkg::DIV_LAST)
                    begin
                        busy_next = 1'b0;
                        done_next = 1'b1;
                    end
                end
                gssim_pkg::OP_SQRT:
                begin
                    // digit-by-digit root, two radicand bits a cycle
                    ge = (x_reg >= root_sum);
                    if (ge)
                    begin
                        x_next = x_reg - root_sum;
                        y_next = (y_reg >> 1) + z_reg[gssim_pkg::UNIT_W-1:0];
                    end
                    else
                    begin
                        y_next = y_reg >> 1;
                    end
                    z_next   = z_reg >> 2;
                    cnt_next = cnt_reg + 1'b1;
                    if (cnt_reg == gssim_pkg::SQRT_LAST)
                    begin
                        busy_next = 1'b0;
                        done_next = 1'b1;
                    end
                end
                default:
                begin
                    busy_next = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_reg   <= gssim_pkg::OP_NONE;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            op_reg   <= op_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
    end

    always_comb
    begin
        rsp.busy = busy_reg;
        rsp.done = done_reg;
        unique case (op_reg)
            gssim_pkg::OP_MUL:  rsp.result = z_reg[gssim_pkg::UNIT_W-1:0];
            gssim_pkg::OP_DIV:  rsp.result = x_reg;
            gssim_pkg::OP_SQRT: rsp.result = y_reg;
            default:            rsp.result = '0;
        endcase
    end

endmodule

>>> rtl/global_ssim_accumulator_unit.sv
// channel | direction | handshake          | payload
// in      | into      | in_valid, in_stall  | ref_pixel, test_pixel, last_pixel
// out     | out of    | out_valid, out_stall| ssim_fixed, too_few_samples
//
// a word without last_pixel is added to the registered sums; in_stall stays low in idle
// a last word starts the closing math on one shared serial unit (multiply,
// divide, square root, one bit or digit a cycle): nine divides, six shift-add
// multiplies and a square root
// in_stall is high from the last word until its result is in the output register
// the output register lets the next image stream in while out_stall holds a result
// rst_n clears the sums, the sequencer and the output valid asynchronously
module global_ssim_accumulator_unit #(
    parameter int MAX_SAMPLES_LOG2 = 24
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [7:0]         ref_pixel,
    input  logic [7:0]         test_pixel,
    input  logic               last_pixel,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [17:0] ssim_fixed,
    output logic               too_few_samples
);

    localparam int L = MAX_SAMPLES_LOG2;

    gssim_pkg::state_t state_reg, state_next;

    // running sums
    logic [L:0]    count;
    logic [L+7:0]  sum_ref, sum_test;
    logic [L+15:0] sum_sq_ref, sum_sq_test, sum_cross;
    logic [L:0]    count_m1;

    logic in_take;
    logic out_free;
    logic acc_clear;

    // shared unit handshake
    gssim_pkg::unit_req_t req;
    gssim_pkg::unit_rsp_t rsp;
    logic                 started_reg, started_next;
    gssim_pkg::op_t       op_sel;
    gssim_pkg::word_t     op_a, op_b;

    // closing math intermediates (fixed point per stage)
    logic [23:0]      mx_reg, my_reg;
    logic [31:0]      mxx_reg, myy_reg, mxy_reg;
    logic [32:0]      qx_reg, qy_reg, qxy_reg;
    logic [30:0]      vx_reg, vy_reg;
    gssim_pkg::word_t vv_reg;
    logic [31:0]      sd_reg;
    logic             dneg_reg;
    logic [32:0]      dmag_reg;
    logic [33:0]      cmag_reg;
    logic             tneg_reg;
    logic [34:0]      tmag_reg;
    gssim_pkg::word_t b_reg, c_reg, s_reg, p_reg;
    logic [17:0]      ssim_reg;
    logic             few_reg;

    gssim_pkg::word_t den_b, den_c, den_s;
    gssim_pkg::word_t res_q16, res_q24, res_q32;
    logic [32:0]      dvx, dvy;
    logic [17:0]      r_sat;

    // output register
    logic               out_valid_reg, out_valid_next;
    logic signed [17:0] ssim_out_reg;
    logic               few_out_reg;

    gssim_accum #(
        .MAX_SAMPLES_LOG2(L)
    ) u_accum (
        .clk         (clk),
        .rst_n       (rst_n),
        .take        (in_take),
        .clear       (acc_clear),
        .ref_pixel   (ref_pixel),
        .test_pixel  (test_pixel),
        .count       (count),
        .sum_ref     (sum_ref),
        .sum_test    (sum_test),
        .sum_sq_ref  (sum_sq_ref),
        .sum_sq_test (sum_sq_test),
        .sum_cross   (sum_cross)
    );

    gssim_serial_unit u_unit (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    assign in_stall  = (state_reg != gssim_pkg::S_IDLE);
    assign in_take   = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign acc_clear = (state_reg == gssim_pkg::S_DONE) && out_free;
    assign count_m1  = count - (L+1)'(1);

    // denominators, each carries the +1 of the stabilizing constant
    assign den_b = gssim_pkg::word_t'(qx_reg) + gssim_pkg::word_t'(qy_reg)
                   + gssim_pkg::ONE_Q16;
    assign den_c = gssim_pkg::word_t'(vx_reg) + gssim_pkg::word_t'(vy_reg)
                   + gssim_pkg::ONE_Q16;
    assign den_s = gssim_pkg::word_t'(sd_reg) + gssim_pkg::ONE_Q16;

    // rounded rescale of the unit result
    assign res_q16 = (rsp.result + gssim_pkg::RND_Q16) >> 16;
    assign res_q24 = (rsp.result + gssim_pkg::RND_Q24) >> 24;
    assign res_q32 = (rsp.result + gssim_pkg::RND_Q32) >> 32;

    assign dvx = {1'b0, mxx_reg} - qx_reg;
    assign dvy = {1'b0, myy_reg} - qy_reg;

    // magnitude saturation, negative side reaches one step further
    always_comb
    begin
        if (tneg_reg)
            r_sat = (res_q32 > gssim_pkg::word_t'(gssim_pkg::SSIM_NEG_MAX))
                    ? gssim_pkg::SSIM_NEG_MAX : res_q32[17:0];
        else
            r_sat = (res_q32 > gssim_pkg::word_t'(gssim_pkg::SSIM_POS_MAX))
                    ? gssim_pkg::SSIM_POS_MAX : res_q32[17:0];
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            gssim_pkg::S_IDLE: if (in_take && last_pixel) state_next = gssim_pkg::S_CHK;
            gssim_pkg::S_CHK:
                state_next = (count < (L+1)'(2)) ? gssim_pkg::S_DONE : gssim_pkg::S_MX;
            gssim_pkg::S_MX:   if (rsp.done) state_next = gssim_pkg::S_MY;
            gssim_pkg::S_MY:   if (rsp.done) state_next = gssim_pkg::S_MXX;
            gssim_pkg::S_MXX:  if (rsp.done) state_next = gssim_pkg::S_MYY;
            gssim_pkg::S_MYY:  if (rsp.done) state_next = gssim_pkg::S_MXY;
            gssim_pkg::S_MXY:  if (rsp.done) state_next = gssim_pkg::S_QX;
            gssim_pkg::S_QX:   if (rsp.done) state_next = gssim_pkg::S_QY;
            gssim_pkg::S_QY:   if (rsp.done) state_next = gssim_pkg::S_QXY;
            gssim_pkg::S_QXY:  if (rsp.done) state_next = gssim_pkg::S_VAR;
            gssim_pkg::S_VAR:  state_next = gssim_pkg::S_VV;
            gssim_pkg::S_VV:   if (rsp.done) state_next = gssim_pkg::S_SD;
            gssim_pkg::S_SD:   if (rsp.done) state_next = gssim_pkg::S_CDIV;
            gssim_pkg::S_CDIV: if (rsp.done) state_next = gssim_pkg::S_TMAG;
            gssim_pkg::S_TMAG: state_next = gssim_pkg::S_B;
            gssim_pkg::S_B:    if (rsp.done) state_next = gssim_pkg::S_C;
            gssim_pkg::S_C:    if (rsp.done) state_next = gssim_pkg::S_S;
            gssim_pkg::S_S:    if (rsp.done) state_next = gssim_pkg::S_P;
            gssim_pkg::S_P:    if (rsp.done) state_next = gssim_pkg::S_R;
            gssim_pkg::S_R:    if (rsp.done) state_next = gssim_pkg::S_DONE;
            gssim_pkg::S_DONE: if (out_free) state_next = gssim_pkg::S_IDLE;
            default:           state_next = gssim_pkg::S_IDLE;
        endcase
    end

    // operation and operands for each step
    always_comb
    begin
        op_sel = gssim_pkg::OP_NONE;
        op_a   = '0;
        op_b   = '0;
        unique case (state_reg)
            gssim_pkg::S_MX:
            begin
                op_sel = gssim_pkg::OP_DIV;
                op_a   = (gssim_pkg::word_t'(sum_ref) << 16) + gssim_pkg::word_t'(count >> 1);
                op_b   = gssim_pkg::word_t'(count);
            end
            gssim_pkg::S_MY:
            begin
                op_sel = gssim_pkg::OP_DIV;
                op_a   = (gssim_pkg::word_t'(sum_test) << 16) + gssim_pkg::word_t'(count >> 1);
                op_b   = gssim_pkg::word_t'(count);
            end
            gssim_pkg::S_MXX:
            begin
                op_sel = gssim_pkg::OP_DIV;
                op_a   = (gssim_pkg::word_t'(sum_sq_ref) << 16)
                         + gssim_pkg::word_t'(count >> 1);
                op_b   = gssim_pkg::word_t'(count);
            end
            gssim_pkg::S_MYY:
            begin
                op_sel = gssim_pkg::OP_DIV;
                op_a   = (gssim_pkg::word_t'(sum_sq_test) << 16)
                         + gssim_pkg::word_t'(count >> 1);
                op_b   = gssim_pkg::word_t'(count);
            end
            gssim_pkg::S_MXY:
            begin
                op_sel = gssim_pkg::OP_DIV;
                op_a   = (gssim_pkg::word_t'(sum_cross) << 16)
                         + gssim_pkg::word_t'(count >> 1);
                op_b   = gssim_pkg::word_t'(count);
            end
            gssim_pkg::S_QX:
            begin
                op_sel = gssim_pkg::OP_MUL;
                op_a   = gssim_pkg::word_t'(mx_reg);
                op_b   = gssim_pkg::word_t'(mx_reg);
            end
            gssim_pkg::S_QY:
            begin
                op_sel = gssim_pkg::OP_MUL;
                op_a   = gssim_pkg::word_t'(my_reg);
                op_b   = gssim_pkg::word_t'(my_reg);
            end
            gssim_pkg::S_QXY:
            begin
                op_sel = gssim_pkg::OP_MUL;
                op_a   = gssim_pkg::word_t'(mx_reg);
                op_b   = gssim_pkg::word_t'(my_reg);
            end
            gssim_pkg::S_VV:
            begin
                op_sel = gssim_pkg::OP_MUL;
                op_a   = gssim_pkg::word_t'(vx_reg);
                op_b   = gssim_pkg::word_t'(vy_reg);
            end
            gssim_pkg::S_SD:
            begin
                op_sel = gssim_pkg::OP_SQRT;
                op_a   = vv_reg;
            end
            gssim_pkg::S_CDIV:
            begin
                // unbiased covariance: d + rnd(d / (n-1))
                op_sel = gssim_pkg::OP_DIV;
                op_a   = gssim_pkg::word_t'(dmag_reg) + gssim_pkg::word_t'(count_m1 >> 1);
                op_b   = gssim_pkg::word_t'(count_m1);
            end
            gssim_pkg::S_B:
            begin
                op_sel = gssim_pkg::OP_DIV;
                op_a   = (gssim_pkg::word_t'({qxy_reg, 1'b0}) + gssim_pkg::ONE_Q16 << 24)
                         + (den_b >> 1);
                op_b   = den_b;
            end
            gssim_pkg::S_C:
            begin
                op_sel = gssim_pkg::OP_DIV;
                op_a   = (gssim_pkg::word_t'({sd_reg, 1'b0}) + gssim_pkg::ONE_Q16 << 24)
                         + (den_c >> 1);
                op_b   = den_c;
            end
            gssim_pkg::S_S:
            begin
                op_sel = gssim_pkg::OP_DIV;
                op_a   = (gssim_pkg::word_t'(tmag_reg) << 24) + (den_s >> 1);
                op_b   = den_s;
            end
            gssim_pkg::S_P:
            begin
                op_sel = gssim_pkg::OP_MUL;
                op_a   = b_reg;
                op_b   = c_reg;
            end
            gssim_pkg::S_R:
            begin
                op_sel = gssim_pkg::OP_MUL;
                op_a   = p_reg;
                op_b   = s_reg;
            end
            default:
            begin
                op_sel = gssim_pkg::OP_NONE;
            end
        endcase
    end

    // one start per step, held off until the step's result comes back
    assign started_next = rsp.done ? 1'b0 : (started_reg || req.start);

    always_comb
    begin
        req.start = (op_sel != gssim_pkg::OP_NONE) && !started_reg;
        req.op    = op_sel;
        req.a     = op_a;
        req.b     = op_b;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= gssim_pkg::S_IDLE;
            started_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            started_reg   <= started_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // capture each step's result
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            gssim_pkg::S_CHK: few_reg <= (count < (L+1)'(2));
            gssim_pkg::S_MX:  if (rsp.done) mx_reg <= rsp.result[23:0];
            gssim_pkg::S_MY:  if (rsp.done) my_reg <= rsp.result[23:0];
            gssim_pkg::S_MXX: if (rsp.done) mxx_reg <= rsp.result[31:0];
            gssim_pkg::S_MYY: if (rsp.done) myy_reg <= rsp.result[31:0];
            gssim_pkg::S_MXY: if (rsp.done) mxy_reg <= rsp.result[31:0];
            gssim_pkg::S_QX:  if (rsp.done) qx_reg <= res_q16[32:0];
            gssim_pkg::S_QY:  if (rsp.done) qy_reg <= res_q16[32:0];
            gssim_pkg::S_QXY: if (rsp.done) qxy_reg <= res_q16[32:0];
            gssim_pkg::S_VAR:
            begin
                // variance floored at zero and capped to 31 bits
                if ({1'b0, mxx_reg} <= qx_reg)
                    vx_reg <= '0;
                else
                    vx_reg <= (dvx > gssim_pkg::VAR_CAP) ? '1 : dvx[30:0];
                if ({1'b0, myy_reg} <= qy_reg)
                    vy_reg <= '0;
                else
                    vy_reg <= (dvy > gssim_pkg::VAR_CAP) ? '1 : dvy[30:0];
                dneg_reg <= ({1'b0, mxy_reg} < qxy_reg);
                dmag_reg <= ({1'b0, mxy_reg} < qxy_reg) ? (qxy_reg - {1'b0, mxy_reg})
                                                        : ({1'b0, mxy_reg} - qxy_reg);
            end
            gssim_pkg::S_VV:  if (rsp.done) vv_reg <= rsp.result;
            gssim_pkg::S_SD:  if (rsp.done) sd_reg <= rsp.result[31:0];
            gssim_pkg::S_CDIV:
                if (rsp.done) cmag_reg <= {1'b0, dmag_reg} + rsp.result[33:0];
            gssim_pkg::S_TMAG:
            begin
                // t = cov + 1, kept as sign and magnitude
                if (dneg_reg)
                begin
                    tneg_reg <= (cmag_reg > 34'h10000);
                    tmag_reg <= (cmag_reg > 34'h10000) ? 35'(cmag_reg - 34'h10000)
                                                       : 35'(34'h10000 - cmag_reg);
                end
                else
                begin
                    tneg_reg <= 1'b0;
                    tmag_reg <= 35'(cmag_reg) + 35'h10000;
                end
            end
            gssim_pkg::S_B:   if (rsp.done) b_reg <= rsp.result;
            gssim_pkg::S_C:   if (rsp.done) c_reg <= rsp.result;
            gssim_pkg::S_S:   if (rsp.done) s_reg <= rsp.result;
            gssim_pkg::S_P:   if (rsp.done) p_reg <= res_q24;
            gssim_pkg::S_R:
                if (rsp.done) ssim_reg <= tneg_reg ? (18'd0 - r_sat) : r_sat;
            default:
            begin
            end
        endcase
    end

    // output register
    always_comb
    begin
        if (acc_clear)
            out_valid_next = 1'b1;
        else if (out_stall)
            out_valid_next = out_valid_reg;
        else
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (acc_clear)
        begin
            ssim_out_reg <= few_reg ? 18'sd0 : $signed(ssim_reg);
            few_out_reg  <= few_reg;
        end
    end

    assign out_valid       = out_valid_reg;
    assign ssim_fixed      = ssim_out_reg;
    assign too_few_samples = few_out_reg;

`ifndef NO_ASSERTIONS
    a_unit_idle_on_start: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |-> !rsp.busy)
        else $error("shared unit started while busy");

    a_last_starts_math: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && last_pixel) |=> (state_reg == gssim_pkg::S_CHK))
        else $error("last word did not start closing math");

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg == gssim_pkg::S_DONE))
        else $error("result appeared outside the done step");

    a_few_gives_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && too_few_samples) |-> (ssim_fixed == 18'sd0))
        else $error("too few samples but nonzero ssim");
`endif

endmodule
